### rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion wrappers, compiled out when ASSERT_OFF is defined.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
// Property must hold at every clock edge outside reset.
`define ASSERT_HOLDS(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
// Antecedent in one cycle implies consequent in the next.
`define ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);
`else
`define ASSERT_HOLDS(label, clk, rstn, prop, msg)
`define ASSERT_NEXT(label, clk, rstn, ante, cons, msg)
`endif

`endif

### rtl/dqq_pkg.sv
// ---------------------------------------------------------------------------
// dqq_pkg
// Shared constants, codes and types of the ordered identifier queue.
// ---------------------------------------------------------------------------
package dqq_pkg;

    localparam int DEPTH   = 16;
    localparam int ID_BITS = 16;
    localparam int CNT_W   = 5;

    typedef enum logic [1:0] {
        KIND_INSERT = 2'd0,
        KIND_REMOVE = 2'd1,
        KIND_CLEAR  = 2'd2,
        KIND_PEEK   = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        ST_DONE     = 2'd0,
        ST_PRESENT  = 2'd1,
        ST_NOTFOUND = 2'd2,
        ST_FULL     = 2'd3
    } status_t;

    // Command broadcast to every cell
    typedef struct packed {
        logic               load;   // append key at the tail cell
        logic               shift;  // close the gap behind the matching cell
        logic [ID_BITS-1:0] key;
    } cell_cmd_t;

endpackage

### rtl/dqq_cell.sv
// ---------------------------------------------------------------------------
// dqq_cell
// One queue slot: compares its entry, appends at the tail, shifts on remove.
// ---------------------------------------------------------------------------
module dqq_cell (
    input  logic                        aclk,
    input  dqq_pkg::cell_cmd_t          cmd,
    input  logic                        occ,        // slot holds a live entry
    input  logic                        tail,       // first free slot
    input  logic                        shift_in,   // an earlier cell matched
    input  logic [dqq_pkg::ID_BITS-1:0] nbr_data,   // next cell's entry
    output logic                        shift_out,
    output logic                        match,
    output logic [dqq_pkg::ID_BITS-1:0] data_out,   // stored entry
    output logic [dqq_pkg::ID_BITS-1:0] data_next
);

    logic [dqq_pkg::ID_BITS-1:0] data_reg;

    assign match     = occ && (data_reg == cmd.key);
    assign shift_out = shift_in | match;
    assign data_out  = data_reg;

    always_comb begin
        if (cmd.shift && shift_out) begin
            data_next = nbr_data;
        end else if (cmd.load && tail) begin
            data_next = cmd.key;
        end else begin
            data_next = data_reg;
        end
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
    end

endmodule

### rtl/dedup_ordered_id_queue_top.sv
// ---------------------------------------------------------------------------
// dedup_ordered_id_queue_top
// Ordered identifier queue with duplicate suppression and removal, built
// as a row of slot cells.
// ---------------------------------------------------------------------------
//  Channel  | Direction | tdata (low bit up)                         | tuser
//  ---------+-----------+--------------------------------------------+---------
//  s_       | in        | key_id[15:0]                               | kind[1:0]
//  m_       | out       | status[1:0], head_valid, head_id[15:0],    | -
//           |           | entry_count[4:0]                           |
//
//  One transaction per cycle unless m_ stalls: every cell compares its entry
//  with the key in parallel and the hit ripples down the cell chain, so an
//  operation settles in its accept cycle and the result appears on the next.
//  Reset (aresetn low, synchronous) empties the queue and drops m_tvalid;
//  slot contents are not cleared, only the count.
//  s_tready is high whenever the result register is empty or being drained,
//  so a stalled m_ side holds the block after one buffered result.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module dedup_ordered_id_queue_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,    // key_id[15:0]
    input  logic [1:0]  s_tuser,    // kind[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata     // status[1:0], head_valid[2], head_id[18:3],
                                    // entry_count[23:19]
);

    localparam int DEPTH   = dqq_pkg::DEPTH;
    localparam int ID_BITS = dqq_pkg::ID_BITS;
    localparam int CNT_W   = dqq_pkg::CNT_W;

    logic                      accept;
    dqq_pkg::kind_t            kind;
    logic [ID_BITS-1:0]        key;
    dqq_pkg::cell_cmd_t        cmd;

    logic [CNT_W-1:0]          count_reg, count_next;
    logic                      full, found;
    dqq_pkg::status_t          status;

    logic [DEPTH:0]            chain;
    logic [DEPTH-1:0]          occ, tail, match;
    logic [ID_BITS-1:0]        cell_next [DEPTH];
    logic [ID_BITS-1:0]        cell_data [DEPTH];
    logic [ID_BITS-1:0]        nbr      [DEPTH];
    logic [ID_BITS-1:0]        head_next;

    logic                      m_valid_reg;
    logic [23:0]               m_data_reg;

    assign s_tready = !m_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign kind     = dqq_pkg::kind_t'(s_tuser);
    assign key      = s_tdata[ID_BITS-1:0];

    assign full     = (count_reg == CNT_W'(DEPTH));
    assign chain[0] = 1'b0;
    assign found    = chain[DEPTH];

    // Cell row; occupancy and tail position decoded from the count.
    // Neighbour data is the next cell's stored entry.
    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        assign occ[i]  = (count_reg > CNT_W'(i));
        assign tail[i] = (count_reg == CNT_W'(i));
        if (i == DEPTH - 1) begin : g_last
            assign nbr[i] = '0;
        end else begin : g_mid
            assign nbr[i] = cell_data[i+1];
        end

        dqq_cell u_cell (
            .aclk      (aclk),
            .cmd       (cmd),
            .occ       (occ[i]),
            .tail      (tail[i]),
            .shift_in  (chain[i]),
            .nbr_data  (nbr[i]),
            .shift_out (chain[i+1]),
            .match     (match[i]),
            .data_out  (cell_data[i]),
            .data_next (cell_next[i])
        );
    end

    always_comb begin
        cmd        = '0;
        cmd.key    = key;
        status     = dqq_pkg::ST_DONE;
        count_next = count_reg;
        unique case (kind)
            dqq_pkg::KIND_INSERT: begin
                if (found) begin
                    status = dqq_pkg::ST_PRESENT;
                end else if (full) begin
                    status = dqq_pkg::ST_FULL;
                end else begin
                    cmd.load   = accept;
                    count_next = count_reg + CNT_W'(1);
                end
            end
            dqq_pkg::KIND_REMOVE: begin
                if (found) begin
                    cmd.shift  = accept;
                    count_next = count_reg - CNT_W'(1);
                end else begin
                    status = dqq_pkg::ST_NOTFOUND;
                end
            end
            dqq_pkg::KIND_CLEAR: begin
                count_next = '0;
            end
            dqq_pkg::KIND_PEEK: begin
                count_next = count_reg;
            end
            default: begin
                count_next = count_reg;
            end
        endcase
    end

    assign head_next = (count_next != '0) ? cell_next[0] : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (accept) begin
                count_reg   <= count_next;
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            m_data_reg <= {count_next, head_next, (count_next != '0), status};
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    `ASSERT_HOLDS(a_count_bound, aclk, aresetn, count_reg <= CNT_W'(DEPTH), "count beyond depth")
    `ASSERT_HOLDS(a_no_dup, aclk, aresetn, $onehot0(match), "identifier held twice")
    `ASSERT_NEXT(a_ins_grow, aclk, aresetn, cmd.load, count_reg == $past(count_reg) + CNT_W'(1), "no grow")
    `ASSERT_NEXT(a_rem_shrink, aclk, aresetn, cmd.shift, count_reg == $past(count_reg) - CNT_W'(1), "no shrink")
    `ASSERT_HOLDS(a_head_flag, aclk, aresetn, !m_valid_reg || (m_data_reg[2] == (m_data_reg[23:19] != '0)), "bad head flag")

endmodule

### bench/dedup_queue_checker.sv
// ---------------------------------------------------------------------------
// dedup_queue_checker
// Watches both channels of the ordered identifier queue, keeps its own copy
// of the queue contents and compares every result field with the predicted
// status, head and count.
// ---------------------------------------------------------------------------
module dedup_queue_checker
    import dqq_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [15:0] s_tdata,    // key_id[15:0]
    input  logic [1:0]  s_tuser,    // kind[1:0]
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [23:0] m_tdata,    // status, head_valid, head_id, entry_count
    output int unsigned mismatches,
    output int unsigned due_count
);

    // Same bit order as m_tdata: status in the lowest bits
    typedef struct packed {
        logic [CNT_W-1:0] entry_count;
        logic [15:0]      head_id;
        logic             head_valid;
        status_t          status;
    } queue_result_t;

    localparam int PRINT_CAP = 50;

    logic [ID_BITS-1:0] id_row [DEPTH];
    int unsigned        id_num = 0;
    int unsigned        err_total = 0;
    queue_result_t      due_results [$];

    task automatic report(string what, int unsigned got, int unsigned want);
        if (err_total < PRINT_CAP)
            $display("[%0t] mismatch on %s: got 0x%0h, want 0x%0h", $time, what, got, want);
        err_total++;
    endtask

    // Applies one operation to the shadow queue and returns the result due
    function automatic queue_result_t apply_queue_op(kind_t op, logic [15:0] key_in);
        logic [ID_BITS-1:0] key;
        int                 pos;
        queue_result_t      res;
        key = key_in[ID_BITS-1:0];
        pos = -1;
        for (int i = 0; i < int'(id_num); i++)
            if (pos < 0 && id_row[i] == key) pos = i;
        res.status = ST_DONE;
        case (op)
            KIND_INSERT: begin
                if (pos >= 0)
                    res.status = ST_PRESENT;   // duplicate wins over full
                else if (id_num >= DEPTH)
                    res.status = ST_FULL;
                else begin
                    id_row[id_num] = key;
                    id_num++;
                end
            end
            KIND_REMOVE: begin
                if (pos < 0)
                    res.status = ST_NOTFOUND;
                else begin
                    for (int i = pos; i + 1 < int'(id_num); i++)
                        id_row[i] = id_row[i + 1];
                    id_num--;
                end
            end
            KIND_CLEAR: id_num = 0;
            default: ;
        endcase
        res.head_valid  = (id_num != 0);
        res.head_id     = (id_num != 0) ? 16'(id_row[0]) : 16'd0;
        res.entry_count = CNT_W'(id_num);
        return res;
    endfunction

    always @(posedge aclk) begin
        queue_result_t got;
        queue_result_t want;
        if (!aresetn) begin
            id_num = 0;
            due_results.delete();
        end else begin
            // result first: it always belongs to an older transaction
            if (m_tvalid && m_tready) begin
                got = m_tdata;
                if (due_results.size() == 0)
                    report("result with none due", m_tdata, 0);
                else begin
                    want = due_results.pop_front();
                    if (got.status !== want.status)
                        report("status", got.status, want.status);
                    if (got.head_valid !== want.head_valid)
                        report("head_valid", got.head_valid, want.head_valid);
                    if (got.head_id !== want.head_id)
                        report("head_id", got.head_id, want.head_id);
                    if (got.entry_count !== want.entry_count)
                        report("entry_count", got.entry_count, want.entry_count);
                end
            end
            if (s_tvalid && s_tready)
                due_results.push_back(apply_queue_op(kind_t'(s_tuser), s_tdata));
        end
        mismatches <= err_total;
        due_count  <= due_results.size();
    end

endmodule

### bench/dedup_ordered_id_queue_top_test.sv
// ---------------------------------------------------------------------------
// dedup_ordered_id_queue_top_test
// Drives insert, remove, clear and peek transactions into the ordered
// identifier queue with bursty input and a stalling result side; the
// checker beside the block predicts and compares every result.
// ---------------------------------------------------------------------------
module dedup_ordered_id_queue_top_test;
    import dqq_pkg::*;

    localparam int          RANDOM_ITEMS = 800;
    localparam int          POOL_SIZE    = 20;     // a little above DEPTH: hits and misses
    localparam int          HOLD_CYCLES  = 64;     // long receiver hold-off
    localparam int unsigned RUN_LIMIT    = 200000;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata  = 16'd0;   // key_id[15:0]
    logic [1:0]  s_tuser  = 2'd0;    // kind[1:0]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;            // status[1:0], head_valid, head_id[15:0], entry_count[4:0]

    int unsigned mismatches;
    int unsigned due_count;
    int unsigned cycle_cnt = 0;
    int unsigned burst_left = 0;
    logic [15:0] key_pool [POOL_SIZE];

    // 4 time-unit period
    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    dedup_ordered_id_queue_top u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    dedup_queue_checker u_checker (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .mismatches (mismatches),
        .due_count  (due_count)
    );

    // Watchdog: a hung handshake ends the run here
    initial begin
        while (cycle_cnt < RUN_LIMIT) begin
            @(posedge aclk);
            cycle_cnt++;
        end
        $display("[dedup_ordered_id_queue_top] ERROR");
        $finish;
    end

    // Offers one transaction and returns at the edge where it is taken.
    // Bursts of random length; between most bursts tvalid drops for a random gap
    // and the idle data wanders so that ignored lanes get exercised.
    task automatic offer_op(kind_t op, logic [15:0] key);
        int unsigned gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap != 0) begin
                s_tvalid <= 1'b0;
                s_tdata  <= 16'($urandom);
                s_tuser  <= 2'($urandom);
                repeat (gap) @(posedge aclk);
            end
            burst_left = $urandom_range(1, 24);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= key;
        do @(posedge aclk); while (!s_tready);
        burst_left--;
    endtask

    // Fill phases lean on inserts, drain phases on removes; clear stays rare
    // so the queue regularly reaches its full depth.
    function automatic kind_t pick_kind(bit filling);
        int unsigned r;
        r = $urandom_range(0, 99);
        if (filling) begin
            if (r < 70)      return KIND_INSERT;
            else if (r < 88) return KIND_REMOVE;
            else if (r < 99) return KIND_PEEK;
            else             return KIND_CLEAR;
        end else begin
            if (r < 25)      return KIND_INSERT;
            else if (r < 80) return KIND_REMOVE;
            else if (r < 96) return KIND_PEEK;
            else             return KIND_CLEAR;
        end
    endfunction

    // Mostly keys from a small pool so duplicates and removals hit
    function automatic logic [15:0] pick_key();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 85)      return key_pool[$urandom_range(0, POOL_SIZE - 1)];
        else if (r < 88) return 16'hFFFF;
        else if (r < 91) return 16'h0000;
        else             return 16'($urandom);
    endfunction

    // Receiver: stretches of always-ready, random stalls and mostly stalled;
    // the third stretch is a long hold-off so the block backs up and drops
    // s_tready while the sender keeps offering.
    initial begin
        int unsigned stretch;
        int unsigned len;
        int unsigned pick;
        stretch = 0;
        wait (aresetn);
        forever begin
            stretch++;
            pick = (stretch == 3) ? 9 : $urandom_range(0, 15);
            if (pick == 9) begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end else begin
                len = $urandom_range(4, 40);
                repeat (len) begin
                    if (pick < 5)
                        m_tready <= 1'b1;
                    else if (pick < 12)
                        m_tready <= $urandom_range(0, 1);
                    else
                        m_tready <= ($urandom_range(0, 3) == 0);
                    @(posedge aclk);
                end
            end
        end
    end

    // Stimulus and verdict
    initial begin
        bit          filling;
        int unsigned phase_left;
        filling    = 1'b0;
        phase_left = 0;
        for (int i = 0; i < POOL_SIZE; i++)
            key_pool[i] = 16'($urandom);

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: empty queue, key extremes, duplicate, absent key,
        // removal of the head, filling up, full queue, middle removal, clear
        offer_op(KIND_PEEK,   16'h0000);
        offer_op(KIND_REMOVE, 16'h0000);   // remove from empty
        offer_op(KIND_INSERT, 16'h0000);
        offer_op(KIND_INSERT, 16'hFFFF);
        offer_op(KIND_INSERT, 16'hFFFF);   // already present
        offer_op(KIND_REMOVE, 16'h1234);   // absent key
        offer_op(KIND_REMOVE, 16'h0000);   // head leaves, FFFF moves up
        for (int i = 0; i < DEPTH - 1; i++)
            offer_op(KIND_INSERT, 16'h0001 << i);
        offer_op(KIND_INSERT, 16'h1234);   // full: rejected
        offer_op(KIND_INSERT, 16'h0004);   // full but present: reports present
        offer_op(KIND_REMOVE, 16'h0010);   // gap in the middle
        offer_op(KIND_CLEAR,  16'hA5A5);

        // Random: alternating fill and drain phases, pool refreshed a little
        // each phase so stale entries eventually get cleared out
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (phase_left == 0) begin
                filling    = ~filling;
                phase_left = $urandom_range(40, 120);
                repeat (4) key_pool[$urandom_range(0, POOL_SIZE - 1)] = 16'($urandom);
            end
            phase_left--;
            offer_op(pick_kind(filling), pick_key());
        end

        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (due_count != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);

        if (mismatches == 0 && due_count == 0)
            $display("[dedup_ordered_id_queue_top] OK");
        else
            $display("[dedup_ordered_id_queue_top] ERROR");
        $finish;
    end

endmodule
